/* sv/terminal_key_escape_encoder_core_assert.svh */
// Assertion macros shared by the key escape encoder modules.
`ifndef TERMINAL_KEY_ESCAPE_ENCODER_CORE_ASSERT_SVH
`define TERMINAL_KEY_ESCAPE_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define TKEE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define TKEE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define TKEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TKEE_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define TKEE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define TKEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/tkee_pkg.sv */
// Shared types, key codes, characters and lookup functions of the key escape encoder.
`timescale 1ns / 1ps

package tkee_pkg;

   localparam int SEQ_MAX   = 7;
   localparam int LEN_W     = 3;
   localparam int Q_DEPTH   = 2;

   // Key codes that open a class of keys, single keys, and the first unassigned code
   localparam logic [4:0] KEY_INSERT = 5'd6;
   localparam logic [4:0] KEY_RETURN = 5'd10;
   localparam logic [4:0] KEY_TAB    = 5'd11;
   localparam logic [4:0] KEY_BKSP   = 5'd12;
   localparam logic [4:0] KEY_F1     = 5'd14;
   localparam logic [4:0] KEY_F5     = 5'd18;
   localparam logic [4:0] KEY_LIMIT  = 5'd26;

   localparam logic [7:0] CHAR_ESC   = 8'h1B;
   localparam logic [7:0] CHAR_LBRK  = 8'h5B;
   localparam logic [7:0] CHAR_SS3   = 8'h4F;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_HT    = 8'h09;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   // One encoded key: bytes in send order from index 0, and the count
   typedef struct packed {
      logic [SEQ_MAX-1:0][7:0] bytes;
      logic [LEN_W-1:0]        len;
   } tkee_seq_type;

   // Final character of the cursor keys, Home and End
   function automatic logic [7:0] cursor_final(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h41;  // A
         3'd1:    ch = 8'h42;  // B
         3'd2:    ch = 8'h43;  // C
         3'd3:    ch = 8'h44;  // D
         3'd4:    ch = 8'h48;  // H
         3'd5:    ch = 8'h46;  // F
         default: ch = 8'h41;
      endcase
      return ch;
   endfunction

   // Number of a tilde key as {tens char or CHAR_NONE, ones char}
   function automatic logic [15:0] tilde_chars(input logic [4:0] key);
      logic [15:0] ch;
      unique case (key)
         5'd6:    ch = {CHAR_NONE, 8'h32};
         5'd7:    ch = {CHAR_NONE, 8'h33};
         5'd8:    ch = {CHAR_NONE, 8'h35};
         5'd9:    ch = {CHAR_NONE, 8'h36};
         5'd18:   ch = {8'h31, 8'h35};
         5'd19:   ch = {8'h31, 8'h37};
         5'd20:   ch = {8'h31, 8'h38};
         5'd21:   ch = {8'h31, 8'h39};
         5'd22:   ch = {8'h32, 8'h30};
         5'd23:   ch = {8'h32, 8'h31};
         5'd24:   ch = {8'h32, 8'h33};
         5'd25:   ch = {8'h32, 8'h34};
         default: ch = {CHAR_NONE, 8'h30};
      endcase
      return ch;
   endfunction

endpackage

/* sv/tkee_front.sv */
// Front end: holds the cursor mode register and turns a key word into its byte sequence.
`timescale 1ns / 1ps

module tkee_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic [4:0]            key_code,
   input  logic                  shift_held,
   input  logic                  alt_held,
   input  logic                  ctrl_held,
   output tkee_pkg::tkee_seq_type seq
);

   logic        app_cursor_ff;
   logic        app_cursor_in;
   logic        mod;
   logic [7:0]  m_char;
   logic [7:0]  fin;
   logic [15:0] tchars;
   logic [2:0]  k;
   logic [4:0]  pf_off;

   assign app_cursor_in = csr_wr_en ? csr_wr_data : app_cursor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_cursor_ff <= 1'b0;
      end else begin
         app_cursor_ff <= app_cursor_in;
      end
   end

   assign mod    = shift_held | alt_held | ctrl_held;
   assign m_char = tkee_pkg::CHAR_ONE + {5'd0, ctrl_held, alt_held, shift_held};
   assign pf_off = key_code - tkee_pkg::KEY_F1;
   assign tchars = tkee_pkg::tilde_chars(key_code);

   always_comb begin
      seq = '0;
      k   = 3'd2;
      fin = tkee_pkg::cursor_final(key_code[2:0]);
      if (key_code >= tkee_pkg::KEY_F1 && key_code < tkee_pkg::KEY_F5) begin
         fin = tkee_pkg::CHAR_P + {6'd0, pf_off[1:0]};
      end

      if (key_code < tkee_pkg::KEY_INSERT ||
          (key_code >= tkee_pkg::KEY_F1 && key_code < tkee_pkg::KEY_F5)) begin
         seq.bytes[0] = tkee_pkg::CHAR_ESC;
         if (mod) begin
            seq.bytes[1] = tkee_pkg::CHAR_LBRK;
            seq.bytes[2] = tkee_pkg::CHAR_ONE;
            seq.bytes[3] = tkee_pkg::CHAR_SEMI;
            seq.bytes[4] = m_char;
            seq.bytes[5] = fin;
            seq.len      = 3'd6;
         end else begin
            // function keys always use SS3; cursor keys follow the mode
            seq.bytes[1] = (app_cursor_ff || key_code >= tkee_pkg::KEY_F1) ?
                           tkee_pkg::CHAR_SS3 : tkee_pkg::CHAR_LBRK;
            seq.bytes[2] = fin;
            seq.len      = 3'd3;
         end
      end else if (key_code < tkee_pkg::KEY_RETURN ||
                   (key_code >= tkee_pkg::KEY_F5 && key_code < tkee_pkg::KEY_LIMIT)) begin
         seq.bytes[0] = tkee_pkg::CHAR_ESC;
         seq.bytes[1] = tkee_pkg::CHAR_LBRK;
         if (tchars[15:8] != tkee_pkg::CHAR_NONE) begin
            seq.bytes[2] = tchars[15:8];
            seq.bytes[3] = tchars[7:0];
            k            = 3'd4;
         end else begin
            seq.bytes[2] = tchars[7:0];
            k            = 3'd3;
         end
         if (mod) begin
            seq.bytes[k]        = tkee_pkg::CHAR_SEMI;
            seq.bytes[k + 3'd1] = m_char;
            seq.bytes[k + 3'd2] = tkee_pkg::CHAR_TILDE;
            seq.len             = k + 3'd3;
         end else begin
            seq.bytes[k] = tkee_pkg::CHAR_TILDE;
            seq.len      = k + 3'd1;
         end
      end else if (key_code < tkee_pkg::KEY_F1) begin
         if (key_code == tkee_pkg::KEY_TAB && shift_held) begin
            seq.bytes[0] = tkee_pkg::CHAR_ESC;
            seq.bytes[1] = tkee_pkg::CHAR_LBRK;
            seq.bytes[2] = tkee_pkg::CHAR_Z;
            seq.len      = 3'd3;
         end else begin
            if (key_code == tkee_pkg::KEY_RETURN) begin
               fin = tkee_pkg::CHAR_CR;
            end else if (key_code == tkee_pkg::KEY_TAB) begin
               fin = tkee_pkg::CHAR_HT;
            end else if (key_code == tkee_pkg::KEY_BKSP) begin
               fin = ctrl_held ? tkee_pkg::CHAR_BS : tkee_pkg::CHAR_DEL;
            end else begin
               fin = tkee_pkg::CHAR_ESC;
            end
            if (alt_held) begin
               seq.bytes[0] = tkee_pkg::CHAR_ESC;
               seq.bytes[1] = fin;
               seq.len      = 3'd2;
            end else begin
               seq.bytes[0] = fin;
               seq.len      = 3'd1;
            end
         end
      end
      // unassigned codes leave a zero length and are dropped
   end

endmodule

/* sv/tkee_queue.sv */
// Two-entry queue of encoded sequences between the front and back ends.
`timescale 1ns / 1ps

`include "terminal_key_escape_encoder_core_assert.svh"

module tkee_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  tkee_pkg::tkee_seq_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output tkee_pkg::tkee_seq_type pop_data
);

   tkee_pkg::tkee_seq_type mem [tkee_pkg::Q_DEPTH];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign push_ready = count_ff != 2'(tkee_pkg::Q_DEPTH);
   assign pop_valid  = count_ff != 2'd0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   `TKEE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= 2'(tkee_pkg::Q_DEPTH), "queue count over depth")
   `TKEE_ASSERT_IMPLIES(a_push_nonempty, clock, reset, push, push_data.len != 3'd0, "empty sequence queued")

endmodule

/* sv/tkee_back.sv */
// Back end: sends the current sequence one byte per word through an output register.
`timescale 1ns / 1ps

`include "terminal_key_escape_encoder_core_assert.svh"

module tkee_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   seq_valid,
   output logic                   seq_ready,
   input  tkee_pkg::tkee_seq_type seq_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_last
);

   tkee_pkg::tkee_seq_type cur_ff, cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [2:0]             pos_ff, pos_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;
   logic                   adv;
   logic                   load_byte;
   logic                   is_last;

   assign adv       = !out_valid_ff || out_ready;
   assign load_byte = adv && cur_valid_ff;
   assign is_last   = pos_ff == cur_ff.len - 3'd1;
   assign seq_ready = !cur_valid_ff || (load_byte && is_last);

   always_comb begin
      out_valid_in = adv ? cur_valid_ff : out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (load_byte) begin
         out_byte_in = cur_ff.bytes[pos_ff];
         out_last_in = is_last;
      end

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (seq_ready) begin
         cur_in       = seq_data;
         cur_valid_in = seq_valid;
         pos_in       = 3'd0;
      end else if (load_byte) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

   `TKEE_ASSERT_IMPLIES(a_pos_in_range, clock, reset, cur_valid_ff, pos_ff < cur_ff.len, "byte position past sequence end")
   `TKEE_ASSERT_NEXT(a_drain_idle, clock, reset, out_valid_ff && out_ready && !cur_valid_ff, !out_valid_ff, "word sent with no sequence behind it")

endmodule

/* sv/terminal_key_escape_encoder_core.sv */
// Top level of the terminal key escape encoder: ports, front end, queue and back end.
`timescale 1ns / 1ps

// Takes one key press per req word (key code plus shift, alt and ctrl) and
// sends the terminal escape sequence for it on the rsp channel, one byte per
// word, with tlast on the final byte. Cursor keys, Home and End give
// ESC [ 1 ; m final when a modifier is held, else ESC O final in application
// cursor mode or ESC [ final; F1 to F4 give ESC O P..S or the modified CSI
// form; Insert, Delete, page keys and F5 to F12 give ESC [ n ~ or
// ESC [ n ; m ~; Return, Tab, Backspace and Escape take an ESC prefix with
// alt, and shift with Tab gives ESC [ Z. The modifier digit m is
// 1 + shift + 2*alt + 4*ctrl. Key codes 26 to 31 are accepted and produce no
// words. Timing: the front end encodes a key in the cycle it is accepted and
// writes it to a two-entry queue; the back end emits one byte per cycle while
// rsp_tready is high, 1 to 7 bytes per key, and sequences follow one another
// with no gap. The first byte of a key passes through the queue, the back
// end's current-sequence register and the output register. req_tready drops
// only while the queue holds two keys, which happens when keys arrive faster
// than their bytes drain. Write csr_wr_en/csr_wr_data (application cursor
// mode) only while no key is in flight.
module terminal_key_escape_encoder_core (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // app_cursor_mode
   // key words
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [4:0] key_code, [5] shift_held,
                                     // [6] alt_held, [7] ctrl_held
   // sequence bytes
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast      // last_byte
);

   tkee_pkg::tkee_seq_type enc_seq;
   tkee_pkg::tkee_seq_type q_seq;
   logic                   q_push_ready;
   logic                   q_pop_valid;
   logic                   q_pop_ready;
   logic                   push_valid;

   // Encode in the front end; words that map to nothing are accepted and dropped
   tkee_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .key_code    (req_tdata[4:0]),
      .shift_held  (req_tdata[5]),
      .alt_held    (req_tdata[6]),
      .ctrl_held   (req_tdata[7]),
      .seq         (enc_seq)
   );

   assign req_tready = q_push_ready;
   assign push_valid = req_tvalid && (enc_seq.len != 3'd0);

   // Hold encoded keys so the front keeps accepting while bytes drain
   tkee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (q_push_ready),
      .push_data  (enc_seq),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_seq)
   );

   // Serialize one sequence at a time through the output register
   tkee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .seq_valid (q_pop_valid),
      .seq_ready (q_pop_ready),
      .seq_data  (q_seq),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

/* bench/terminal_key_escape_encoder_core_test.sv */
// Self-checking bench for the terminal key escape encoder: directed keys, random keys, stalls.
`timescale 1ns / 1ps

module terminal_key_escape_encoder_core_test;

   // Key codes as seen on req_tdata[4:0]; 26 and up are unassigned.
   typedef enum logic [4:0] {
      KC_UP = 5'd0, KC_DOWN, KC_RIGHT, KC_LEFT, KC_HOME, KC_END,
      KC_INSERT, KC_DELETE, KC_PGUP, KC_PGDN,
      KC_RETURN, KC_TAB, KC_BKSP, KC_ESCAPE,
      KC_F1, KC_F2, KC_F3, KC_F4, KC_F5, KC_F6, KC_F7, KC_F8,
      KC_F9, KC_F10, KC_F11, KC_F12,
      KC_UNASSIGNED_FIRST = 5'd26,
      KC_UNASSIGNED_LAST  = 5'd31
   } key_type;

   // Bytes that make up the escape sequences.
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_CSI   = 8'h5B;  // '[' after ESC
   localparam logic [7:0] CH_SS3   = 8'h4F;  // 'O' after ESC
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_BS    = 8'h08;

   localparam int IDLE_PCT      = 21;  // chance per cycle/word that a side idles
   localparam int SETTLE_CYCLES = 8;   // covers acceptance-to-output plus queue depth
   localparam int STALL_CYCLES  = 90;  // long receiver hold-off
   localparam int DRAIN_LIMIT   = 5000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } seq_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;    // [4:0] key_code, [5] shift, [6] alt, [7] ctrl
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;

   // Bench copy of the cursor mode register, updated when the write lands.
   logic       cursor_app_mode = 1'b0;

   seq_byte_type pending_bytes[$];
   int         fail_count = 0;
   int         keys_sent = 0;
   int         unassigned_sent = 0;
   int         bytes_checked = 0;
   int         sequences_closed = 0;

   // quiet: no idling on either side; hold_req kicks off the long receiver stall
   logic       quiet = 1'b0;
   logic       hold_req = 1'b0;
   int         hold_left = 0;

   terminal_key_escape_encoder_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #400_000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Work out the escape sequence for one accepted key and queue its bytes.
   function automatic void predict_escape_bytes(input logic [4:0] key, input logic sh,
                                                input logic al, input logic ct);
      logic [7:0] seq[$];
      logic       modified;
      logic       csi_mod_form;
      logic [7:0] mod_char;
      logic [7:0] letter;
      int         tilde_num;
      modified     = sh | al | ct;
      mod_char     = CH_ZERO + 8'(1 + int'(sh) + 2 * int'(al) + 4 * int'(ct));
      csi_mod_form = 1'b0;
      letter       = CH_P;
      tilde_num    = 0;

      if (key <= KC_END) begin
         case (key)
            KC_UP:    letter = "A";
            KC_DOWN:  letter = "B";
            KC_RIGHT: letter = "C";
            KC_LEFT:  letter = "D";
            KC_HOME:  letter = "H";
            default:  letter = "F";
         endcase
         if (modified) begin
            csi_mod_form = 1'b1;
         end else begin
            seq.push_back(CH_ESC);
            seq.push_back(cursor_app_mode ? CH_SS3 : CH_CSI);
            seq.push_back(letter);
         end
      end else if (key >= KC_F1 && key <= KC_F4) begin
         letter = CH_P + 8'(key - KC_F1);
         if (modified) begin
            csi_mod_form = 1'b1;
         end else begin
            seq.push_back(CH_ESC);
            seq.push_back(CH_SS3);
            seq.push_back(letter);
         end
      end else if (key >= KC_RETURN && key <= KC_ESCAPE) begin
         if (key == KC_TAB && sh) begin
            // back-tab ignores alt and ctrl
            seq.push_back(CH_ESC);
            seq.push_back(CH_CSI);
            seq.push_back(CH_Z);
         end else begin
            if (al) begin
               seq.push_back(CH_ESC);
            end
            case (key)
               KC_RETURN: seq.push_back(CH_CR);
               KC_TAB:    seq.push_back(CH_HT);
               KC_BKSP:   seq.push_back(ct ? CH_BS : CH_DEL);
               default:   seq.push_back(CH_ESC);
            endcase
         end
      end else if (key <= KC_F12) begin
         case (key)
            KC_INSERT: tilde_num = 2;
            KC_DELETE: tilde_num = 3;
            KC_PGUP:   tilde_num = 5;
            KC_PGDN:   tilde_num = 6;
            KC_F5:     tilde_num = 15;
            KC_F6:     tilde_num = 17;
            KC_F7:     tilde_num = 18;
            KC_F8:     tilde_num = 19;
            KC_F9:     tilde_num = 20;
            KC_F10:    tilde_num = 21;
            KC_F11:    tilde_num = 23;
            default:   tilde_num = 24;
         endcase
         seq.push_back(CH_ESC);
         seq.push_back(CH_CSI);
         if (tilde_num >= 10) begin
            seq.push_back(CH_ZERO + 8'(tilde_num / 10));
         end
         seq.push_back(CH_ZERO + 8'(tilde_num % 10));
         if (modified) begin
            seq.push_back(CH_SEMI);
            seq.push_back(mod_char);
         end
         seq.push_back(CH_TILDE);
      end
      // unassigned codes leave seq empty

      if (csi_mod_form) begin
         seq.push_back(CH_ESC);
         seq.push_back(CH_CSI);
         seq.push_back(CH_ONE);
         seq.push_back(CH_SEMI);
         seq.push_back(mod_char);
         seq.push_back(letter);
      end

      foreach (seq[i]) begin
         pending_bytes.push_back('{data: seq[i], last: (i == seq.size() - 1)});
      end
   endfunction

   // Offer one key, wait for the handshake, then record what it should produce.
   // Valid stays high between back-to-back keys; send_key only drops it inside a gap.
   task automatic send_key(input logic [4:0] key, input logic sh, input logic al,
                           input logic ct);
      int gap;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ct, al, sh, key};
      do @(posedge clock); while (!req_tready);
      predict_escape_bytes(key, sh, al, ct);
      keys_sent++;
      if (key >= KC_UNASSIGNED_FIRST) begin
         unassigned_sent++;
      end
   endtask

   // Mostly real keys with random modifiers; a few unassigned codes mixed in.
   task automatic send_random_key();
      logic [4:0] key;
      if ($urandom_range(99) < 8) begin
         key = 5'($urandom_range(KC_UNASSIGNED_FIRST, KC_UNASSIGNED_LAST));
      end else begin
         key = 5'($urandom_range(KC_UP, KC_F12));
      end
      send_key(key, 1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Drop valid and let every outstanding byte drain, plus room for keys that
   // produce nothing but may still be moving through the queue.
   task automatic wait_until_idle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cursor_mode(input logic mode);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      cursor_app_mode  = mode;
      @(posedge clock);
   endtask

   // Receiver: random ready, or a long counted hold-off when asked for one.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left  <= STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Compare every accepted byte with the oldest expected one.
   always @(posedge clock) begin
      seq_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               report_mismatch($sformatf("byte %02h, want %02h", rsp_tdata, want.data));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("last %0b on byte %02h, want %0b",
                                         rsp_tlast, rsp_tdata, want.last));
            end
            bytes_checked++;
            if (want.last) begin
               sequences_closed++;
            end
         end
      end
   end

   // Cursor, Home and End in both modes; first ones run on the reset mode.
   task automatic test_cursor_keys();
      for (int k = KC_UP; k <= KC_END; k++) begin
         send_key(5'(k), 1'b0, 1'b0, 1'b0);
      end
      write_cursor_mode(1'b1);
      send_key(KC_UP, 1'b0, 1'b0, 1'b0);
      send_key(KC_END, 1'b0, 1'b0, 1'b0);
      send_key(KC_LEFT, 1'b1, 1'b1, 1'b1);   // modifier digit at its top
      send_key(KC_HOME, 1'b1, 1'b0, 1'b0);   // modifier digit at its bottom
      write_cursor_mode(1'b0);
   endtask

   // Tilde keys with one- and two-digit numbers, and the F1-F4 forms.
   task automatic test_tilde_and_function_keys();
      send_key(KC_INSERT, 1'b0, 1'b0, 1'b0);
      send_key(KC_DELETE, 1'b1, 1'b0, 1'b1);
      send_key(KC_F1, 1'b0, 1'b0, 1'b0);
      send_key(KC_F4, 1'b0, 1'b1, 1'b0);
      send_key(KC_F5, 1'b0, 1'b0, 1'b0);
      send_key(KC_F11, 1'b0, 1'b0, 1'b0);
      send_key(KC_F12, 1'b1, 1'b1, 1'b1);
   endtask

   // Return, Tab, Backspace and Escape with and without the alt prefix.
   task automatic test_control_keys();
      send_key(KC_RETURN, 1'b0, 1'b1, 1'b0);
      send_key(KC_TAB, 1'b0, 1'b0, 1'b0);
      send_key(KC_TAB, 1'b1, 1'b1, 1'b1);    // back-tab wins over alt and ctrl
      send_key(KC_BKSP, 1'b0, 1'b0, 1'b1);
      send_key(KC_BKSP, 1'b0, 1'b1, 1'b0);
      send_key(KC_ESCAPE, 1'b0, 1'b0, 1'b0);
      send_key(KC_ESCAPE, 1'b0, 1'b1, 1'b0);
   endtask

   // Unassigned codes must produce nothing and must not disturb what follows.
   task automatic test_unassigned_keys();
      send_key(KC_UNASSIGNED_FIRST, 1'b0, 1'b0, 1'b0);
      send_key(KC_UNASSIGNED_LAST, 1'b1, 1'b1, 1'b1);
      send_key(KC_RIGHT, 1'b0, 1'b0, 1'b0);
   endtask

   // Random keys over several phases, alternating the cursor mode; one phase
   // runs without any idling so sequences go out back to back.
   task automatic test_random_keys();
      int assigned;
      for (int phase = 0; phase < 5; phase++) begin
         write_cursor_mode(1'(phase + 1));
         quiet    <= (phase == 2);
         assigned  = 0;
         while (assigned < 17) begin
            send_random_key();
            if (req_tdata[4:0] < KC_UNASSIGNED_FIRST) begin
               assigned++;
            end
         end
      end
      quiet <= 1'b0;
   endtask

   // Hold the receiver off while keys keep coming, so the queue fills and
   // req_tready has to drop.
   task automatic test_output_stall();
      write_cursor_mode(1'($urandom));
      quiet    <= 1'b1;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      for (int i = 0; i < 12; i++) begin
         send_key(5'($urandom_range(KC_UP, KC_F12)), 1'($urandom), 1'($urandom), 1'($urandom));
      end
      wait_until_idle();
      quiet <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cursor_keys();
      test_tilde_and_function_keys();
      test_control_keys();
      test_unassigned_keys();
      test_random_keys();
      test_output_stall();

      wait_until_idle();
      if (pending_bytes.size() != 0) begin
         report_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
      end

      $display("covered %0d keys (%0d unassigned) in both cursor modes, with idling",
               keys_sent, unassigned_sent);
      $display("and a long output stall; %0d bytes in %0d sequences compared",
               bytes_checked, sequences_closed);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/tkee_pkg.sv
sv/tkee_front.sv
sv/tkee_queue.sv
sv/tkee_back.sv
sv/terminal_key_escape_encoder_core.sv
bench/terminal_key_escape_encoder_core_test.sv
